>>> rtl/nlex_pkg.sv
// ----------------------------------------------------------------------------
// nlex_pkg
// Shared types and constants for the numeric literal lexer.
// ----------------------------------------------------------------------------
package nlex_pkg;

   localparam int EXP_BITS   = 15;
   localparam int EXP_EXT_W  = EXP_BITS + 4;
   localparam int INT_W      = 63;
   localparam int FRAC_W     = 60;
   localparam int EXPV_W     = 15;
   localparam int MASK_NUM   = 4;
   localparam int MASK_W     = 64;
   localparam int CSR_IDX_W  = 2;
   localparam int RSP_DATA_W = 208;

   localparam logic [INT_W-1:0]    INT_LIMIT = {INT_W{1'b1}};
   localparam logic [EXP_BITS-1:0] EXP_LIMIT = {EXP_BITS{1'b1}};

   typedef enum logic [1:0] {
      ERR_NONE  = 2'd0,
      ERR_CHAR  = 2'd1,
      ERR_RANGE = 2'd2,
      ERR_END   = 2'd3
   } err_code_type;

   typedef struct packed {
      logic       is_space;
      logic       is_delim;
      logic       is_minus;
      logic       is_zero;
      logic       is_point;
      logic       is_e;
      logic       is_x;
      logic       dig_ok10;
      logic       dig_ok16;
      logic [3:0] dig_val;
   } char_class_type;

   typedef struct packed {
      logic                ok;
      err_code_type        error_code;
      logic                negative;
      logic [INT_W-1:0]    int_part;
      logic [FRAC_W-1:0]   frac_num;
      logic [FRAC_W-1:0]   frac_den;
      logic                exp_negative;
      logic [EXPV_W-1:0]   exp_value;
      logic                is_integer;
   } result_type;

endpackage

>>> rtl/nlex_csr.sv
// ----------------------------------------------------------------------------
// nlex_csr
// Delimiter mask registers and per-character classification.
// ----------------------------------------------------------------------------
module nlex_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   input  logic [nlex_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [nlex_pkg::MASK_W-1:0]          csr_data,
   input  logic [7:0]                           ch,
   output nlex_pkg::char_class_type             cls
);

   logic [nlex_pkg::MASK_W-1:0] mask_ff [nlex_pkg::MASK_NUM];
   logic [nlex_pkg::MASK_W-1:0] sel_mask;
   logic                        is_dec;
   logic                        is_hexl;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < nlex_pkg::MASK_NUM; i++) begin
            mask_ff[i] <= '0;
         end
      end else if (csr_valid) begin
         mask_ff[csr_index] <= csr_data;
      end
   end

   always_comb begin
      sel_mask     = mask_ff[ch[7:6]];
      is_dec       = (ch >= 8'h30) && (ch <= 8'h39);
      is_hexl      = ((ch >= 8'h61) && (ch <= 8'h66)) || ((ch >= 8'h41) && (ch <= 8'h46));
      cls.is_space = (ch == 8'h20) || (ch == 8'h09) || (ch == 8'h0A) || (ch == 8'h0D);
      cls.is_delim = sel_mask[ch[5:0]];
      cls.is_minus = (ch == 8'h2D);
      cls.is_zero  = (ch == 8'h30);
      cls.is_point = (ch == 8'h2E);
      cls.is_e     = (ch == 8'h65) || (ch == 8'h45);
      cls.is_x     = (ch == 8'h78) || (ch == 8'h58);
      cls.dig_ok10 = is_dec;
      cls.dig_ok16 = is_dec || is_hexl;
      cls.dig_val  = is_dec ? ch[3:0] : (ch[3:0] + 4'd9);
   end

endmodule

>>> rtl/nlex_core.sv
// ----------------------------------------------------------------------------
// nlex_core
// Lexer state machine and accumulators; one character per transaction.
// ----------------------------------------------------------------------------
module nlex_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      take,
   input  logic                      kind,
   input  nlex_pkg::char_class_type  cls,
   output logic                      res_valid,
   output nlex_pkg::result_type      res
);

   typedef enum logic [3:0] {
      LX_START, LX_MINUS, LX_LZERO, LX_LPOINT, LX_INT, LX_HEX,
      LX_POINT, LX_EXP_INIT, LX_EXP_MINUS, LX_EXP, LX_SWALLOW
   } lex_state_type;

   lex_state_type                   state_ff, state_in;
   logic                            sign_ff, sign_in;
   logic                            esign_ff, esign_in;
   logic [nlex_pkg::INT_W-1:0]      int_ff, int_in;
   logic [nlex_pkg::FRAC_W-1:0]     frac_ff, frac_in;
   logic [nlex_pkg::FRAC_W-1:0]     den_ff, den_in;
   logic [nlex_pkg::EXP_BITS-1:0]   exp_ff, exp_in;

   logic [nlex_pkg::INT_W+4:0]      int10_new, int16_new;
   logic [63:0]                     frac_new, den_new;
   logic [nlex_pkg::EXP_EXT_W-1:0]  exp_new;
   nlex_pkg::err_code_type          int10_err, int16_err, frac_err, exp_err, err;
   logic                            close, clear, good;
   logic [31:0]                     exp_wide;

   always_comb begin
      int10_new = (nlex_pkg::INT_W+5)'({int_ff, 3'b0}) + (nlex_pkg::INT_W+5)'({int_ff, 1'b0})
                  + (nlex_pkg::INT_W+5)'(cls.dig_val);
      int16_new = (nlex_pkg::INT_W+5)'({int_ff, 4'b0}) + (nlex_pkg::INT_W+5)'(cls.dig_val);
      frac_new  = 64'({frac_ff, 3'b0}) + 64'({frac_ff, 1'b0}) + 64'(cls.dig_val);
      den_new   = 64'({den_ff, 3'b0}) + 64'({den_ff, 1'b0});
      exp_new   = nlex_pkg::EXP_EXT_W'({exp_ff, 3'b0}) + nlex_pkg::EXP_EXT_W'({exp_ff, 1'b0})
                  + nlex_pkg::EXP_EXT_W'(cls.dig_val);

      int10_err = !cls.dig_ok10 ? nlex_pkg::ERR_CHAR :
                  (int10_new > (nlex_pkg::INT_W+5)'(nlex_pkg::INT_LIMIT)) ? nlex_pkg::ERR_RANGE
                  : nlex_pkg::ERR_NONE;
      int16_err = !cls.dig_ok16 ? nlex_pkg::ERR_CHAR :
                  (int16_new > (nlex_pkg::INT_W+5)'(nlex_pkg::INT_LIMIT)) ? nlex_pkg::ERR_RANGE
                  : nlex_pkg::ERR_NONE;
      frac_err  = !cls.dig_ok10 ? nlex_pkg::ERR_CHAR :
                  ((frac_new > 64'(nlex_pkg::INT_LIMIT)) || (den_new > 64'(nlex_pkg::INT_LIMIT)))
                  ? nlex_pkg::ERR_RANGE : nlex_pkg::ERR_NONE;
      exp_err   = !cls.dig_ok10 ? nlex_pkg::ERR_CHAR :
                  (exp_new > nlex_pkg::EXP_EXT_W'(nlex_pkg::EXP_LIMIT)) ? nlex_pkg::ERR_RANGE
                  : nlex_pkg::ERR_NONE;

      state_in = state_ff;
      sign_in  = sign_ff;
      esign_in = esign_ff;
      int_in   = int_ff;
      frac_in  = frac_ff;
      den_in   = den_ff;
      exp_in   = exp_ff;
      err      = nlex_pkg::ERR_NONE;
      close    = 1'b0;
      clear    = 1'b0;

      if (kind) begin
         if (state_ff == LX_SWALLOW) clear = 1'b1;
         else                        close = 1'b1;
      end else if (cls.is_space || cls.is_delim) begin
         if (state_ff == LX_START && cls.is_space) begin
            clear = 1'b0;
         end else if (state_ff == LX_SWALLOW) begin
            clear = 1'b1;
         end else begin
            close = 1'b1;
         end
      end else begin
         unique case (state_ff)
            LX_START, LX_MINUS: begin
               if (cls.is_minus) begin
                  if (state_ff == LX_MINUS) begin
                     err = nlex_pkg::ERR_CHAR;
                  end else begin
                     state_in = LX_MINUS;
                     sign_in  = 1'b1;
                  end
               end else if (cls.is_zero) begin
                  state_in = LX_LZERO;
               end else if (cls.is_point) begin
                  state_in = LX_LPOINT;
               end else begin
                  state_in = LX_INT;
                  err      = int10_err;
                  int_in   = int10_new[nlex_pkg::INT_W-1:0];
               end
            end
            LX_LZERO, LX_INT: begin
               if (state_ff == LX_LZERO && cls.is_x) begin
                  state_in = LX_HEX;
               end else if (cls.is_point) begin
                  state_in = LX_POINT;
               end else if (cls.is_e) begin
                  state_in = LX_EXP_INIT;
               end else begin
                  state_in = LX_INT;
                  err      = int10_err;
                  int_in   = int10_new[nlex_pkg::INT_W-1:0];
               end
            end
            LX_HEX: begin
               err    = int16_err;
               int_in = int16_new[nlex_pkg::INT_W-1:0];
            end
            LX_LPOINT, LX_POINT: begin
               if (cls.is_e) begin
                  if (state_ff == LX_LPOINT) err = nlex_pkg::ERR_CHAR;
                  else                       state_in = LX_EXP_INIT;
               end else begin
                  state_in = LX_POINT;
                  err      = frac_err;
                  frac_in  = frac_new[nlex_pkg::FRAC_W-1:0];
                  den_in   = den_new[nlex_pkg::FRAC_W-1:0];
               end
            end
            LX_EXP_INIT, LX_EXP_MINUS: begin
               if (cls.is_minus) begin
                  if (state_ff == LX_EXP_MINUS) begin
                     err = nlex_pkg::ERR_CHAR;
                  end else begin
                     state_in = LX_EXP_MINUS;
                     esign_in = 1'b1;
                  end
               end else begin
                  state_in = LX_EXP;
                  err      = exp_err;
                  exp_in   = exp_new[nlex_pkg::EXP_BITS-1:0];
               end
            end
            LX_EXP: begin
               err    = exp_err;
               exp_in = exp_new[nlex_pkg::EXP_BITS-1:0];
            end
            default: begin
               state_in = state_ff;
            end
         endcase
      end

      good = (state_ff == LX_LZERO) || (state_ff == LX_HEX) || (state_ff == LX_INT) ||
             (state_ff == LX_POINT) || (state_ff == LX_EXP);

      res_valid = close || (err != nlex_pkg::ERR_NONE);
      exp_wide  = 32'(exp_ff);

      res.ok           = close && good;
      res.error_code   = close ? (good ? nlex_pkg::ERR_NONE : nlex_pkg::ERR_END) : err;
      res.negative     = sign_ff;
      res.int_part     = int_ff;
      res.frac_num     = frac_ff;
      res.frac_den     = den_ff;
      res.exp_negative = esign_ff;
      res.exp_value    = exp_wide[nlex_pkg::EXPV_W-1:0];
      res.is_integer   = (frac_ff == '0) && (den_ff == nlex_pkg::FRAC_W'(1)) && (exp_ff == '0);

      if (close || clear || (err != nlex_pkg::ERR_NONE)) begin
         state_in = (err != nlex_pkg::ERR_NONE) ? LX_SWALLOW : LX_START;
         sign_in  = 1'b0;
         esign_in = 1'b0;
         int_in   = '0;
         frac_in  = '0;
         den_in   = nlex_pkg::FRAC_W'(1);
         exp_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LX_START;
         sign_ff  <= 1'b0;
         esign_ff <= 1'b0;
         int_ff   <= '0;
         frac_ff  <= '0;
         den_ff   <= nlex_pkg::FRAC_W'(1);
         exp_ff   <= '0;
      end else if (take) begin
         state_ff <= state_in;
         sign_ff  <= sign_in;
         esign_ff <= esign_in;
         int_ff   <= int_in;
         frac_ff  <= frac_in;
         den_ff   <= den_in;
         exp_ff   <= exp_in;
      end
   end

endmodule

>>> rtl/nlex_out_reg.sv
// ----------------------------------------------------------------------------
// nlex_out_reg
// Result register between the lexer and the result stream.
// ----------------------------------------------------------------------------
module nlex_out_reg (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               load,
   input  logic [nlex_pkg::RSP_DATA_W-1:0]    load_data,
   output logic                               room,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [nlex_pkg::RSP_DATA_W-1:0]    rsp_tdata
);

   logic                              valid_ff, valid_in;
   logic [nlex_pkg::RSP_DATA_W-1:0]   data_ff;

   assign room       = !valid_ff || rsp_tready;
   assign valid_in   = load ? 1'b1 : (rsp_tready ? 1'b0 : valid_ff);
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         data_ff <= load_data;
      end
   end

endmodule

>>> rtl/numeric_literal_lexer_top.sv
// ----------------------------------------------------------------------------
// numeric_literal_lexer_top
// Streaming lexer for numeric literals (decimal, 0x hex, fraction, exponent).
// One character or end-of-input mark is taken per cycle, back to back; each
// transaction finishes in the cycle it is accepted, the lexer state and
// accumulators updating in place and any result landing in the result
// register, which presents it on the next cycle. req_tready drops only while
// that result register is full and rsp_tready is low. A token yields one
// result when closed by whitespace, a delimiter or end of input, or at once
// on an error, after which characters up to the next terminator are dropped.
// Delimiter masks are written through the csr port, one 64-bit word each.
// ----------------------------------------------------------------------------
module numeric_literal_lexer_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,  // [7:0] ch
   input  logic                               req_tuser,  // [0] kind
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [0] ok, [2:1] error_code, [3] negative, [66:4] int_part,
   // [126:67] frac_num, [186:127] frac_den, [187] exp_negative,
   // [202:188] exp_value, [203] is_integer, [207:204] zero
   output logic [nlex_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [nlex_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [nlex_pkg::MASK_W-1:0]        csr_data
);

   nlex_pkg::char_class_type             cls;
   nlex_pkg::result_type                 res;
   logic                                 res_valid;
   logic                                 take;
   logic                                 room;
   logic [nlex_pkg::RSP_DATA_W-1:0]      res_data;

   assign csr_ready  = 1'b1;
   assign req_tready = room;
   assign take       = req_tvalid && room;

   assign res_data = {4'b0, res.is_integer, res.exp_value, res.exp_negative, res.frac_den,
                      res.frac_num, res.int_part, res.negative, res.error_code, res.ok};

   nlex_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .ch        (req_tdata),
      .cls       (cls)
   );

   nlex_core u_core (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .kind      (req_tuser),
      .cls       (cls),
      .res_valid (res_valid),
      .res       (res)
   );

   nlex_out_reg u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (take && res_valid),
      .load_data  (res_data),
      .room       (room),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

>>> tb/numeric_literal_lexer_top_tb.sv
// ----------------------------------------------------------------------------
// numeric_literal_lexer_top_tb
// Streams characters and end marks into the lexer and checks every token.
// A scoreboard class keeps its own copy of the lexer state and the delimiter
// masks and predicts each result from the accepted characters. Results are
// checked field by field in order. The run covers a short directed sequence,
// then randomized numeric literals (decimal, hex, fraction, exponent, and
// overflow boundaries) with injected noise, under several delimiter settings
// and several patterns of input gaps and output back-pressure.
// ----------------------------------------------------------------------------
module numeric_literal_lexer_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [nlex_pkg::CSR_IDX_W-1:0] DELIM_MASK_0 = 2'd0;
   localparam logic [nlex_pkg::CSR_IDX_W-1:0] DELIM_MASK_1 = 2'd1;
   localparam logic [nlex_pkg::CSR_IDX_W-1:0] DELIM_MASK_2 = 2'd2;
   localparam logic [nlex_pkg::CSR_IDX_W-1:0] DELIM_MASK_3 = 2'd3;

   localparam bit [63:0] INT_MAX = {1'b0, nlex_pkg::INT_LIMIT};
   localparam bit [63:0] EXP_MAX = 64'(nlex_pkg::EXP_LIMIT);
   // bytes kept clear of the delimiter flags so literals still get through
   localparam bit [63:0] KEEP_LO = 64'h03FF_E000_0000_0000;
   localparam bit [63:0] KEEP_HI = 64'h0100_007E_0100_007E;
   localparam bit [63:0] PUNCT_LO = 64'h0C00_1200_0000_0000;
   localparam bit [63:0] PUNCT_HI = 64'h1000_0000_0000_0000;

   typedef enum int {
      ST_START, ST_MINUS, ST_LZERO, ST_LPOINT, ST_INT, ST_HEX,
      ST_POINT, ST_EXP_INIT, ST_EXP_MINUS, ST_EXP, ST_SWALLOW
   } lex_state_type;

   typedef enum int { ACC_INT, ACC_FRAC, ACC_EXP } acc_sel_type;

   class lexer_scoreboard;
      bit [63:0]              delim_mask [4];
      lex_state_type          state;
      bit                     neg;
      bit                     exp_neg;
      bit [63:0]              int_acc;
      bit [63:0]              frac_acc;
      bit [63:0]              den_acc;
      bit [63:0]              exp_acc;
      nlex_pkg::result_type   token_q [$];
      int                     mismatches;
      int                     tokens_checked;
      int                     code_count [4];

      function new();
         foreach (delim_mask[i]) delim_mask[i] = '0;
         clear(ST_START);
      endfunction

      function void clear(lex_state_type next);
         state    = next;
         neg      = 1'b0;
         exp_neg  = 1'b0;
         int_acc  = '0;
         frac_acc = '0;
         den_acc  = 64'd1;
         exp_acc  = '0;
      endfunction

      function bit is_space(logic [7:0] c);
         return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D;
      endfunction

      function bit is_delim(logic [7:0] c);
         return delim_mask[c[7:6]][c[5:0]];
      endfunction

      function nlex_pkg::err_code_type push_digit(logic [7:0] c, int base, acc_sel_type sel);
         int        v;
         bit [63:0] d;
         bit [63:0] b;
         v = -1;
         b = 64'(base);
         if (c >= "0" && c <= "9")
            v = int'(c[3:0]);
         else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F"))
            v = int'(c[3:0]) + 9;
         if (v >= base) v = -1;
         if (v < 0) return nlex_pkg::ERR_CHAR;
         d = 64'(v);
         case (sel)
            ACC_INT: begin
               if (int_acc > (INT_MAX - d) / b) return nlex_pkg::ERR_RANGE;
               int_acc = int_acc * b + d;
            end
            ACC_FRAC: begin
               if (frac_acc > (INT_MAX - d) / b || den_acc > INT_MAX / b)
                  return nlex_pkg::ERR_RANGE;
               frac_acc = frac_acc * b + d;
               den_acc  = den_acc * b;
            end
            default: begin
               if (exp_acc > (EXP_MAX - d) / b) return nlex_pkg::ERR_RANGE;
               exp_acc = exp_acc * b + d;
            end
         endcase
         return nlex_pkg::ERR_NONE;
      endfunction

      function void queue_token(bit good, nlex_pkg::err_code_type code);
         nlex_pkg::result_type r;
         r.ok           = good;
         r.error_code   = code;
         r.negative     = neg;
         r.int_part     = int_acc[nlex_pkg::INT_W-1:0];
         r.frac_num     = frac_acc[nlex_pkg::FRAC_W-1:0];
         r.frac_den     = den_acc[nlex_pkg::FRAC_W-1:0];
         r.exp_negative = exp_neg;
         r.exp_value    = exp_acc[nlex_pkg::EXPV_W-1:0];
         r.is_integer   = frac_acc == 0 && den_acc == 1 && exp_acc == 0;
         token_q.push_back(r);
      endfunction

      function void close_token();
         if (state inside {ST_LZERO, ST_HEX, ST_INT, ST_POINT, ST_EXP})
            queue_token(1'b1, nlex_pkg::ERR_NONE);
         else
            queue_token(1'b0, nlex_pkg::ERR_END);
         clear(ST_START);
      endfunction

      function nlex_pkg::err_code_type int_or_mark(logic [7:0] c);
         if (c == ".") begin
            state = ST_POINT;
            return nlex_pkg::ERR_NONE;
         end
         if (c == "e" || c == "E") begin
            state = ST_EXP_INIT;
            return nlex_pkg::ERR_NONE;
         end
         state = ST_INT;
         return push_digit(c, 10, ACC_INT);
      endfunction

      function nlex_pkg::err_code_type consume_char(logic [7:0] c);
         case (state)
            ST_START, ST_MINUS: begin
               if (c == "-") begin
                  if (state == ST_MINUS) return nlex_pkg::ERR_CHAR;
                  state = ST_MINUS;
                  neg   = 1'b1;
                  return nlex_pkg::ERR_NONE;
               end
               if (c == "0") begin
                  state = ST_LZERO;
                  return nlex_pkg::ERR_NONE;
               end
               if (c == ".") begin
                  state = ST_LPOINT;
                  return nlex_pkg::ERR_NONE;
               end
               state = ST_INT;
               return push_digit(c, 10, ACC_INT);
            end
            ST_LZERO: begin
               if (c == "x" || c == "X") begin
                  state = ST_HEX;
                  return nlex_pkg::ERR_NONE;
               end
               return int_or_mark(c);
            end
            ST_INT:  return int_or_mark(c);
            ST_HEX:  return push_digit(c, 16, ACC_INT);
            ST_LPOINT, ST_POINT: begin
               if (c == "e" || c == "E") begin
                  if (state == ST_LPOINT) return nlex_pkg::ERR_CHAR;
                  state = ST_EXP_INIT;
                  return nlex_pkg::ERR_NONE;
               end
               state = ST_POINT;
               return push_digit(c, 10, ACC_FRAC);
            end
            ST_EXP_INIT, ST_EXP_MINUS: begin
               if (c == "-") begin
                  if (state == ST_EXP_MINUS) return nlex_pkg::ERR_CHAR;
                  state   = ST_EXP_MINUS;
                  exp_neg = 1'b1;
                  return nlex_pkg::ERR_NONE;
               end
               state = ST_EXP;
               return push_digit(c, 10, ACC_EXP);
            end
            ST_EXP:  return push_digit(c, 10, ACC_EXP);
            default: return nlex_pkg::ERR_NONE;
         endcase
      endfunction

      // one accepted input transaction
      function void note_input(logic kind, logic [7:0] c);
         nlex_pkg::err_code_type code;
         if (kind) begin
            if (state == ST_SWALLOW) clear(ST_START);
            else close_token();
            return;
         end
         if (is_space(c) || is_delim(c)) begin
            if (state == ST_START && is_space(c)) return;
            if (state == ST_SWALLOW) clear(ST_START);
            else close_token();
            return;
         end
         if (state == ST_SWALLOW) return;
         code = consume_char(c);
         if (code != nlex_pkg::ERR_NONE) begin
            queue_token(1'b0, code);
            clear(ST_SWALLOW);
         end
      endfunction

      function void compare(string field, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, field, want, got);
            mismatches++;
         end
      endfunction

      function void check_result(logic [nlex_pkg::RSP_DATA_W-1:0] d);
         nlex_pkg::result_type e;
         if (token_q.size() == 0) begin
            $display("%0t ns: unexpected result, expected none actual %0h", $time, d);
            mismatches++;
            return;
         end
         e = token_q.pop_front();
         tokens_checked++;
         code_count[e.error_code]++;
         compare("ok",           64'(e.ok),           64'(d[0]));
         compare("error_code",   64'(e.error_code),   64'(d[2:1]));
         compare("negative",     64'(e.negative),     64'(d[3]));
         compare("int_part",     64'(e.int_part),     64'(d[66:4]));
         compare("frac_num",     64'(e.frac_num),     64'(d[126:67]));
         compare("frac_den",     64'(e.frac_den),     64'(d[186:127]));
         compare("exp_negative", 64'(e.exp_negative), 64'(d[187]));
         compare("exp_value",    64'(e.exp_value),    64'(d[202:188]));
         compare("is_integer",   64'(e.is_integer),   64'(d[203]));
         compare("padding",      64'd0,               64'(d[207:204]));
      endfunction
   endclass

   logic                              clock;
   logic                              reset;
   logic                              req_tvalid;
   logic                              req_tready;
   logic [7:0]                        req_tdata;
   logic                              req_tuser;
   logic                              rsp_tvalid;
   logic                              rsp_tready;
   logic [nlex_pkg::RSP_DATA_W-1:0]   rsp_tdata;
   logic                              csr_valid;
   logic                              csr_ready;
   logic [nlex_pkg::CSR_IDX_W-1:0]    csr_index;
   logic [nlex_pkg::MASK_W-1:0]       csr_data;

   lexer_scoreboard sb;
   int send_idle_pct;
   int recv_stall_pct;
   int hold_requests;
   int items_sent;

   numeric_literal_lexer_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("Timeout with %0d results still pending", sb.token_q.size());
      $display("RESULT: ERROR");
      $finish;
   end

   // receiver: random stalls plus long hold-offs on request
   initial begin
      int holds_done;
      int hold_left;
      holds_done = 0;
      hold_left  = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(negedge clock);
         if (hold_requests != holds_done) begin
            holds_done++;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= $urandom_range(99) >= recv_stall_pct;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
   end

   task automatic send_item(logic kind, logic [7:0] c);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tuser  <= kind;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_input(kind, c);
      items_sent++;
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_item(1'b0, s[i]);
   endtask

   task automatic send_digits(int n, bit hex);
      int r;
      repeat (n) begin
         r = hex ? $urandom_range(21) : $urandom_range(9);
         if (r < 10)      send_item(1'b0, 8'h30 + 8'(r));
         else if (r < 16) send_item(1'b0, 8'h61 + 8'(r - 10));
         else             send_item(1'b0, 8'h41 + 8'(r - 16));
      end
   endtask

   function automatic logic [7:0] pick_space();
      case ($urandom_range(3))
         0:       return 8'h20;
         1:       return 8'h09;
         2:       return 8'h0A;
         default: return 8'h0D;
      endcase
   endfunction

   task automatic send_terminator();
      int          t;
      logic [7:0]  c;
      t = $urandom_range(99);
      if (t < 65) begin
         send_item(1'b0, pick_space());
      end else if (t < 85) begin
         c = pick_space();
         for (int i = 0; i < 16; i++) begin
            c = 8'($urandom_range(255));
            if (sb.is_delim(c)) break;
            c = pick_space();
         end
         send_item(1'b0, c);
      end else begin
         send_item(1'b1, 8'($urandom_range(255)));
      end
   endtask

   task automatic random_token();
      int pick;
      int n;
      pick = $urandom_range(99);
      if ($urandom_range(2) == 0) repeat ($urandom_range(1, 2)) send_item(1'b0, pick_space());
      if (pick < 5) begin
         repeat ($urandom_range(1, 3)) send_item(1'b0, 8'($urandom_range(255)));
         send_terminator();
         return;
      end
      if ($urandom_range(3) == 0) send_item(1'b0, "-");
      if (pick < 13) begin
         case ($urandom_range(9))
            0: send_text("9223372036854775807");
            1: send_text("9223372036854775808");
            2: send_text("0x7fffffffffffffff");
            3: send_text("0X8000000000000000");
            4: send_text("1e32767");
            5: send_text("2E-32768");
            6: send_text("0.999999999999999999");
            7: send_text(".1234567890123456789");
            8: send_text("0xFFFFFFFFFFFFFFFF0");
            default: send_text("-1");
         endcase
      end else if (pick < 33) begin
         send_item(1'b0, "0");
         send_item(1'b0, $urandom_range(1) ? "x" : "X");
         n = ($urandom_range(99) < 85) ? $urandom_range(0, 6) : $urandom_range(14, 18);
         send_digits(n, 1'b1);
      end else begin
         n = ($urandom_range(99) < 90) ? $urandom_range(0, 4) : $urandom_range(15, 21);
         send_digits(n, 1'b0);
         if ($urandom_range(1) == 0) begin
            send_item(1'b0, ".");
            n = ($urandom_range(99) < 90) ? $urandom_range(0, 5) : $urandom_range(16, 20);
            send_digits(n, 1'b0);
         end
         if ($urandom_range(9) < 3) begin
            send_item(1'b0, $urandom_range(1) ? "e" : "E");
            if ($urandom_range(1) == 0) send_item(1'b0, "-");
            n = ($urandom_range(99) < 85) ? $urandom_range(0, 3) : $urandom_range(4, 6);
            send_digits(n, 1'b0);
         end
      end
      if ($urandom_range(99) < 12) send_item(1'b0, 8'($urandom_range(255)));
      send_terminator();
   endtask

   // stop sending and let every expected result come out
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.token_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_mask(logic [nlex_pkg::CSR_IDX_W-1:0] idx,
                             logic [nlex_pkg::MASK_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.delim_mask[idx] = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic program_masks(logic [63:0] m0, logic [63:0] m1,
                                logic [63:0] m2, logic [63:0] m3);
      write_mask(DELIM_MASK_0, m0);
      write_mask(DELIM_MASK_1, m1);
      write_mask(DELIM_MASK_2, m2);
      write_mask(DELIM_MASK_3, m3);
      @(posedge clock);
   endtask

   task automatic run_phase(int count, int send_pct, int recv_pct, bit hold, bit pause);
      int goal;
      int half;
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      goal = items_sent + count;
      half = items_sent + count / 2;
      if (hold) hold_requests++;
      while (items_sent < goal) begin
         if (pause && items_sent >= half) begin
            pause = 1'b0;
            settle();
         end
         random_token();
      end
      settle();
   endtask

   initial begin
      int waited;
      sb = new();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_requests  = 0;
      items_sent     = 0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= 1'b0;
      csr_valid  <= 1'b0;
      csr_index  <= '0;
      csr_data   <= '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      program_masks('0, '0, '0, '0);
      // empty token, cut-short tokens, bad characters, swallowing
      send_item(1'b1, 8'hFF);
      send_text("\t-");
      send_item(1'b1, 8'h00);
      send_text("--z ");
      send_text("0x 0.\n.e");
      send_text("\r9E-");
      send_item(1'b1, 8'h5A);
      send_text("g ");
      send_item(1'b0, 8'h80);
      send_item(1'b1, 8'h00);
      settle();
      run_phase(380, 0, 0, 1'b0, 1'b1);

      program_masks(PUNCT_LO, PUNCT_HI, {$urandom, $urandom}, '1);
      run_phase(400, 51, 0, 1'b0, 1'b0);

      program_masks({$urandom, $urandom} & ~KEEP_LO, {$urandom, $urandom} & ~KEEP_HI,
                    '0, {$urandom, $urandom});
      run_phase(400, 0, 51, 1'b1, 1'b0);

      program_masks(PUNCT_LO, PUNCT_HI, '1, {$urandom, $urandom});
      run_phase(400, 27, 27, 1'b1, 1'b0);

      program_masks('1, '1, '1, '1);
      run_phase(60, 0, 0, 1'b0, 1'b0);

      waited = 0;
      while (sb.token_q.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (10) @(posedge clock);
      if (sb.token_q.size() != 0) begin
         $display("%0t ns: %0d expected results never arrived", $time, sb.token_q.size());
         sb.mismatches += sb.token_q.size();
      end

      $display("Sent %0d characters and end marks under five delimiter settings and",
               items_sent);
      $display(
         "four stall patterns; %0d tokens: %0d clean, %0d bad char, %0d overflow, %0d cut short",
         sb.tokens_checked, sb.code_count[nlex_pkg::ERR_NONE],
         sb.code_count[nlex_pkg::ERR_CHAR], sb.code_count[nlex_pkg::ERR_RANGE],
         sb.code_count[nlex_pkg::ERR_END]);
      if (sb.mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
